[design/knn_majority_classifier_core_defines.svh]
// Assertion macros for the classifier checks
`ifndef KNN_MAJORITY_CLASSIFIER_CORE_DEFINES_SVH
`define KNN_MAJORITY_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication
`define KNN_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("knn check failed");

// next-cycle implication
`define KNN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("knn check failed");

`endif

[design/knn_pkg.sv]
package knn_pkg;

    localparam int MAX_REFS   = 256;
    localparam int MAX_DIM    = 8;
    localparam int MAX_K      = 16;
    localparam int MAX_GROUPS = 16;

    localparam int ATTR_W   = 16;
    localparam int LABEL_W  = 4;
    localparam int MODE_W   = 2;
    localparam int ROW_W    = $clog2(MAX_REFS);
    localparam int DIM_W    = $clog2(MAX_DIM);
    localparam int ADDR_W   = ROW_W + DIM_W;
    localparam int CNT_W    = $clog2(MAX_REFS + 1);
    localparam int POS_W    = $clog2(MAX_DIM + 1);
    localparam int KCNT_W   = $clog2(MAX_K + 1);
    localparam int VOTE_W   = $clog2(MAX_K + 1);
    localparam int GIDX_W   = $clog2(MAX_GROUPS + 1);
    localparam int GSEL_W   = $clog2(MAX_GROUPS);
    localparam int DIFF_W   = ATTR_W + 1;
    localparam int SQ_W     = 2 * ATTR_W;
    localparam int DIST_W   = SQ_W + $clog2(MAX_DIM) + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int K_W        = 5;
    localparam int G_W        = 5;
    localparam int D_W        = 4;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_REF   = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_K     = 2'd0,
        CFG_GROUP = 2'd1,
        CFG_DIM   = 2'd2,
        CFG_NONE  = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_DIST,
        S_DRAIN,
        S_VOTE,
        S_PICK,
        S_DONE
    } state_t;

endpackage

[design/knn_ram.sv]
module knn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/knn_majority_classifier_core.sv]
// k-nearest-neighbour majority classifier.
// Input stream: one attribute per transaction. tuser carries the mode
// (reference attribute, query attribute, clear store), tlast marks the last
// attribute of a point. A reference point that ends early has its remaining
// attributes zeroed in a fill state, during which no input is taken.
// On the last query attribute, if k is nonzero and at most the number of
// stored references, the block walks every stored reference through one
// shared subtract-square-accumulate unit, one attribute per cycle, and
// inserts each distance into a sorted list of k entries. The query then
// drains that unit, votes over the kept neighbours and picks among the
// groups in use; s_tready is low for the whole query.
// Result stream: one transaction per query, group and status in tdata. It
// is held in an output register; a stalled receiver keeps the next query
// from finishing, while reference loads still go on until its last attribute.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata, written while idle.
// Reset (aresetn, synchronous) empties the store and restores k=1, 16
// groups and 8 attributes.
module knn_majority_classifier_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [knn_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [knn_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [knn_pkg::IN_TDATA_W-1:0]  s_tdata,   // label[3:0], attr_value[19:4]
    input  logic [knn_pkg::MODE_W-1:0]      s_tuser,   // mode[1:0]
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [knn_pkg::OUT_TDATA_W-1:0] m_tdata    // group[3:0], status[4]
);
    import knn_pkg::*;

    state_t state_reg, state_next;

    logic [K_W-1:0]   k_reg;
    logic [G_W-1:0]   g_reg;
    logic [D_W-1:0]   d_reg;
    logic [K_W-1:0]   k_eff;
    logic [G_W-1:0]   g_eff;
    logic [D_W-1:0]   d_eff;
    logic [D_W-1:0]   d_steps;

    logic [CNT_W-1:0] ref_count_reg;
    logic [POS_W-1:0] pos_reg;
    logic signed [ATTR_W-1:0] qbuf_reg [MAX_DIM];
    logic [ROW_W-1:0] fill_row_reg;
    logic [POS_W-1:0] fill_pos_reg;

    logic [CNT_W-1:0] ri_reg;
    logic [D_W-1:0]   rj_reg;
    logic             rj_last;

    logic             v0_reg, last0_reg;
    logic [DIM_W-1:0] j0_reg;
    logic             v1_reg, last1_reg;
    logic signed [DIFF_W-1:0] diff1_reg;
    logic [LABEL_W-1:0] lab1_reg;
    logic             v2_reg, last2_reg;
    logic [SQ_W-1:0]  sq2_reg;
    logic [LABEL_W-1:0] lab2_reg;
    logic [DIST_W-1:0] acc_reg, acc_sum;
    logic             dv_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [LABEL_W-1:0] dlab_reg;

    logic [DIST_W-1:0]  best_dist_reg [MAX_K];
    logic [LABEL_W-1:0] best_lab_reg  [MAX_K];
    logic [KCNT_W-1:0]  kept_reg;
    logic [MAX_K-1:0]   le_vec;
    logic [KCNT_W-1:0]  ins_pos;
    logic               ins_take;

    logic [VOTE_W-1:0]  votes_reg [MAX_GROUPS];
    logic [GIDX_W-1:0]  idx_reg;
    logic [LABEL_W-1:0] win_reg;
    logic [VOTE_W-1:0]  win_cnt_reg;
    logic [LABEL_W-1:0] vote_lab;
    logic               status_reg;

    logic               m_tvalid_reg;
    logic [LABEL_W-1:0] m_group_reg;
    logic               m_status_reg;

    logic               s_acc;
    mode_t              in_mode;
    logic [LABEL_W-1:0] in_label;
    logic signed [ATTR_W-1:0] in_attr;
    logic               store_room;
    logic               pos_in;

    logic                attr_we;
    logic [ADDR_W-1:0]   attr_waddr;
    logic [ATTR_W-1:0]   attr_wdata;
    logic [ADDR_W-1:0]   attr_raddr;
    logic signed [ATTR_W-1:0] attr_rdata;
    logic                lab_we;
    logic [LABEL_W-1:0]  lab_rdata;
    logic signed [2*DIFF_W-1:0] prod;

    assign k_eff   = (k_reg > K_W'(MAX_K)) ? K_W'(MAX_K) : k_reg;
    assign g_eff   = (g_reg > G_W'(MAX_GROUPS)) ? G_W'(MAX_GROUPS) : g_reg;
    assign d_eff   = (d_reg > D_W'(MAX_DIM)) ? D_W'(MAX_DIM) : d_reg;
    assign d_steps = (d_eff == '0) ? D_W'(1) : d_eff;
    assign rj_last = (rj_reg == d_steps - D_W'(1));

    assign s_tready   = (state_reg == S_IDLE);
    assign s_acc      = s_tvalid && s_tready;
    assign in_mode    = mode_t'(s_tuser);
    assign in_label   = s_tdata[LABEL_W-1:0];
    assign in_attr    = s_tdata[LABEL_W +: ATTR_W];
    assign store_room = (ref_count_reg < CNT_W'(MAX_REFS));
    assign pos_in     = (pos_reg < POS_W'(MAX_DIM));

    assign attr_we    = (s_acc && in_mode == MODE_REF && store_room && pos_in)
                        || (state_reg == S_FILL);
    assign attr_waddr = (state_reg == S_FILL)
                        ? {fill_row_reg, fill_pos_reg[DIM_W-1:0]}
                        : {ref_count_reg[ROW_W-1:0], pos_reg[DIM_W-1:0]};
    assign attr_wdata = (state_reg == S_FILL) ? '0 : in_attr;
    assign attr_raddr = {ri_reg[ROW_W-1:0], rj_reg[DIM_W-1:0]};
    assign lab_we     = s_acc && in_mode == MODE_REF && s_tlast && store_room;

    knn_ram #(.WIDTH(ATTR_W), .DEPTH(MAX_REFS * MAX_DIM)) u_attr_ram (
        .aclk  (aclk),
        .we    (attr_we),
        .waddr (attr_waddr),
        .wdata (attr_wdata),
        .raddr (attr_raddr),
        .rdata (attr_rdata)
    );

    knn_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_REFS)) u_label_ram (
        .aclk  (aclk),
        .we    (lab_we),
        .waddr (ref_count_reg[ROW_W-1:0]),
        .wdata (in_label),
        .raddr (ri_reg[ROW_W-1:0]),
        .rdata (lab_rdata)
    );

    assign prod    = diff1_reg * diff1_reg;
    assign acc_sum = acc_reg + DIST_W'(sq2_reg);

    // stable sorted insert: new entry goes after all kept entries <= it
    always_comb begin
        for (int s = 0; s < MAX_K; s++) begin
            le_vec[s] = (KCNT_W'(s) < kept_reg) && (best_dist_reg[s] <= dist_reg);
        end
        ins_pos  = KCNT_W'($countones(le_vec));
        ins_take = dv_reg && (ins_pos < KCNT_W'(k_eff));
    end

    assign vote_lab = best_lab_reg[idx_reg[KCNT_W-2:0]];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_acc && in_mode == MODE_REF && s_tlast && store_room
                    && (pos_reg + POS_W'(1)) < POS_W'(MAX_DIM)) begin
                    state_next = S_FILL;
                end else if (s_acc && in_mode == MODE_QUERY && s_tlast) begin
                    if (CNT_W'(k_eff) > ref_count_reg) begin
                        state_next = S_DONE;
                    end else if (ref_count_reg == '0 || k_eff == '0) begin
                        state_next = S_VOTE;
                    end else begin
                        state_next = S_DIST;
                    end
                end
            end
            S_FILL: begin
                if (fill_pos_reg == POS_W'(MAX_DIM - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_DIST: begin
                if (rj_last && (ri_reg + CNT_W'(1)) == ref_count_reg) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!(v0_reg || v1_reg || v2_reg || dv_reg)) begin
                    state_next = S_VOTE;
                end
            end
            S_VOTE: begin
                if (idx_reg >= GIDX_W'(kept_reg)) begin
                    state_next = S_PICK;
                end
            end
            S_PICK: begin
                if (idx_reg >= GIDX_W'(g_eff)) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= K_W'(1);
            g_reg <= G_W'(16);
            d_reg <= D_W'(8);
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_K:     k_reg <= cfg_wdata[K_W-1:0];
                CFG_GROUP: g_reg <= cfg_wdata[G_W-1:0];
                CFG_DIM:   d_reg <= cfg_wdata[D_W-1:0];
                default: ;
            endcase
        end
    end

    // load side: positions, query buffer, zero fill
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_count_reg <= '0;
            pos_reg       <= '0;
        end else if (s_acc) begin
            case (in_mode)
                MODE_CLEAR: begin
                    ref_count_reg <= '0;
                    pos_reg       <= '0;
                end
                MODE_REF: begin
                    if (s_tlast) begin
                        pos_reg <= '0;
                        if (store_room) begin
                            ref_count_reg <= ref_count_reg + CNT_W'(1);
                        end
                    end else if (pos_in) begin
                        pos_reg <= pos_reg + POS_W'(1);
                    end
                end
                MODE_QUERY: begin
                    if (s_tlast) begin
                        pos_reg <= '0;
                    end else if (pos_in) begin
                        pos_reg <= pos_reg + POS_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && in_mode == MODE_QUERY) begin
            for (int p = 0; p < MAX_DIM; p++) begin
                if (pos_in && pos_reg[DIM_W-1:0] == DIM_W'(p)) begin
                    qbuf_reg[p] <= in_attr;
                end else if (s_tlast && POS_W'(p) > pos_reg) begin
                    qbuf_reg[p] <= '0;
                end
            end
        end
        if (state_reg == S_IDLE) begin
            fill_row_reg <= ref_count_reg[ROW_W-1:0];
            fill_pos_reg <= pos_reg + POS_W'(1);
        end else if (state_reg == S_FILL) begin
            fill_pos_reg <= fill_pos_reg + POS_W'(1);
        end
    end

    // distance walk: issue, subtract, square, accumulate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            dv_reg <= 1'b0;
        end else begin
            v0_reg <= (state_reg == S_DIST);
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            dv_reg <= v2_reg && last2_reg;
        end
        if (state_reg == S_IDLE) begin
            ri_reg  <= '0;
            rj_reg  <= '0;
            acc_reg <= '0;
        end else begin
            if (state_reg == S_DIST) begin
                if (rj_last) begin
                    rj_reg <= '0;
                    ri_reg <= ri_reg + CNT_W'(1);
                end else begin
                    rj_reg <= rj_reg + D_W'(1);
                end
            end
            if (v2_reg) begin
                acc_reg <= last2_reg ? '0 : acc_sum;
            end
        end
        last0_reg <= rj_last;
        j0_reg    <= rj_reg[DIM_W-1:0];
        last1_reg <= last0_reg;
        lab1_reg  <= lab_rdata;
        diff1_reg <= (d_eff == '0) ? '0
                     : DIFF_W'(attr_rdata) - DIFF_W'(qbuf_reg[j0_reg]);
        last2_reg <= last1_reg;
        lab2_reg  <= lab1_reg;
        sq2_reg   <= SQ_W'(prod);
        dist_reg  <= acc_sum;
        dlab_reg  <= lab2_reg;
    end

    // neighbour list, vote and pick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kept_reg     <= '0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == S_DONE && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    kept_reg <= '0;
                    idx_reg  <= '0;
                end
                S_DIST, S_DRAIN: begin
                    if (ins_take) begin
                        kept_reg <= (kept_reg < KCNT_W'(k_eff))
                                    ? kept_reg + KCNT_W'(1) : kept_reg;
                    end
                    idx_reg <= '0;
                end
                S_VOTE: begin
                    idx_reg <= (idx_reg >= GIDX_W'(kept_reg)) ? '0
                               : idx_reg + GIDX_W'(1);
                end
                S_PICK: begin
                    idx_reg <= idx_reg + GIDX_W'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (ins_take) begin
            for (int s = 0; s < MAX_K; s++) begin
                if (KCNT_W'(s) == ins_pos) begin
                    best_dist_reg[s] <= dist_reg;
                    best_lab_reg[s]  <= dlab_reg;
                end else if (s > 0 && KCNT_W'(s) > ins_pos) begin
                    best_dist_reg[s] <= best_dist_reg[(s > 0) ? s - 1 : 0];
                    best_lab_reg[s]  <= best_lab_reg[(s > 0) ? s - 1 : 0];
                end
            end
        end
        if (state_reg == S_IDLE) begin
            for (int n = 0; n < MAX_GROUPS; n++) begin
                votes_reg[n] <= '0;
            end
            win_reg     <= '0;
            win_cnt_reg <= '0;
            status_reg  <= (CNT_W'(k_eff) > ref_count_reg);
        end
        if (state_reg == S_VOTE && idx_reg < GIDX_W'(kept_reg)
            && G_W'(vote_lab) < g_eff) begin
            votes_reg[vote_lab[GSEL_W-1:0]] <= votes_reg[vote_lab[GSEL_W-1:0]] + VOTE_W'(1);
        end
        if (state_reg == S_PICK && idx_reg < GIDX_W'(g_eff)
            && win_cnt_reg < votes_reg[idx_reg[GSEL_W-1:0]]) begin
            win_reg     <= LABEL_W'(idx_reg);
            win_cnt_reg <= votes_reg[idx_reg[GSEL_W-1:0]];
        end
        if (state_reg == S_DONE && (!m_tvalid_reg || m_tready)) begin
            m_group_reg  <= status_reg ? '0 : win_reg;
            m_status_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - LABEL_W - 1){1'b0}}, m_status_reg, m_group_reg};

endmodule

[design/knn_core_chk.sv]
`include "knn_majority_classifier_core_defines.svh"
module knn_core_chk (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [knn_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import knn_pkg::*;

    `KNN_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `KNN_ASSERT_NOW(a_status_group, m_tvalid && m_tdata[LABEL_W], m_tdata[LABEL_W-1:0] == '0)
    `KNN_ASSERT_NOW(a_result_busy, $rose(m_tvalid), !$past(s_tready))

endmodule

bind knn_majority_classifier_core knn_core_chk u_knn_core_chk (.*);
